@@ design/g3c_pkg.sv @@
// shared constants, types and helpers for the gray 3x3 convolution block
// no dependencies; imported by every module of the block
package g3c_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int PIX_W      = 8;
    localparam int KERN_W     = 3 * PIX_W;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int SUM_W      = PIX_W + 2;
    localparam int LINE_W     = 2 * PIX_W;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    localparam int MAX_RESULTS = 2;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_KERNEL_TOP   = 3'd2,
        CFG_KERNEL_MID   = 3'd3,
        CFG_KERNEL_BOT   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             interior;
        logic             border;
    } pix_meta_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last;
    } result_t;

    // pixel leaving the line store read stage
    typedef struct packed {
        logic             valid;
        pix_meta_t        meta;
        logic [PIX_W-1:0] gray;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
    } win_in_t;

    // results still held in the window pipeline
    typedef struct packed {
        logic [1:0] p2_results;
        logic [1:0] p3_results;
    } win_stat_t;

    // floor(sum / 3) for sums up to 765, via reciprocal 683 / 2048
    function automatic logic [PIX_W-1:0] gray_of(input logic [SUM_W-1:0] sum);
        logic [20:0] prod;
        prod = 21'(sum) * 21'd683;
        return prod[18:11];
    endfunction

endpackage

@@ design/g3c_line_mem.sv @@
// line store: gray values of the two rows above, one 16-bit word per column
// depends on g3c_pkg; synchronous read into an output register
module g3c_line_mem
    import g3c_pkg::*;
(
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [COL_W-1:0]  rd_addr,
    output logic [LINE_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [COL_W-1:0]  wr_addr,
    input  logic [LINE_W-1:0] wr_data
);

    // word layout: row two above in 15:8, row above in 7:0
    logic [LINE_W-1:0] mem [MAX_WIDTH];
    logic [LINE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/g3c_window.sv @@
// 3x3 window, tap products and sum; forms the interior and border results
// depends on g3c_pkg; fed by the line store read stage of the top level
module g3c_window
    import g3c_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  win_in_t           win_in,
    input  logic [KERN_W-1:0] kernel_top,
    input  logic [KERN_W-1:0] kernel_mid,
    input  logic [KERN_W-1:0] kernel_bot,
    output logic              push_int,
    output result_t           res_int,
    output logic              push_brd,
    output result_t           res_brd,
    output win_stat_t         stat
);

    // [0..2] column c-1 top/mid/bottom, [3..5] column c-2
    logic [PIX_W-1:0] win_reg [6];

    logic             p2_valid_reg;
    pix_meta_t        p2_meta_reg;
    logic [PIX_W-1:0] p2_gray_reg [9];

    logic             p3_valid_reg;
    pix_meta_t        p3_meta_reg;
    logic [PIX_W-1:0] p3_prod_reg [9];
    logic [PIX_W-1:0] p3_prod_next [9];

    logic [PIX_W-1:0] acc;
    logic [KERN_W-1:0] kern [3];

    assign kern[0] = kernel_top;
    assign kern[1] = kernel_mid;
    assign kern[2] = kernel_bot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (win_in.valid) begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= win_in.top;
            win_reg[1] <= win_in.mid;
            win_reg[2] <= win_in.gray;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else begin
            p2_valid_reg <= win_in.valid;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    // neighbourhood in row-major order, left/centre/right per row
    always_ff @(posedge aclk) begin
        p2_meta_reg    <= win_in.meta;
        p2_gray_reg[0] <= win_reg[3];
        p2_gray_reg[1] <= win_reg[0];
        p2_gray_reg[2] <= win_in.top;
        p2_gray_reg[3] <= win_reg[4];
        p2_gray_reg[4] <= win_reg[1];
        p2_gray_reg[5] <= win_in.mid;
        p2_gray_reg[6] <= win_reg[5];
        p2_gray_reg[7] <= win_reg[2];
        p2_gray_reg[8] <= win_in.gray;
    end

    // only the low byte of each product reaches the result
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            p3_prod_next[k] = PIX_W'(kern[k / 3][(k % 3) * PIX_W +: PIX_W] * p2_gray_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        p3_meta_reg <= p2_meta_reg;
        for (int k = 0; k < 9; k++) begin
            p3_prod_reg[k] <= p3_prod_next[k];
        end
    end

    always_comb begin
        acc = '0;
        for (int k = 0; k < 9; k++) begin
            acc = acc + p3_prod_reg[k];
        end
    end

    assign push_int = p3_valid_reg & p3_meta_reg.interior;
    assign push_brd = p3_valid_reg & p3_meta_reg.border;

    always_comb begin
        res_int.col   = p3_meta_reg.col - COL_W'(1);
        res_int.row   = p3_meta_reg.row - ROW_W'(1);
        res_int.red   = acc;
        res_int.green = acc;
        res_int.blue  = acc;
        res_int.last  = ~p3_meta_reg.border;

        res_brd.col   = p3_meta_reg.col;
        res_brd.row   = p3_meta_reg.row;
        res_brd.red   = p3_meta_reg.red;
        res_brd.green = p3_meta_reg.green;
        res_brd.blue  = p3_meta_reg.blue;
        res_brd.last  = 1'b1;
    end

    always_comb begin
        stat.p2_results = {1'b0, p2_valid_reg & p2_meta_reg.interior}
                        + {1'b0, p2_valid_reg & p2_meta_reg.border};
        stat.p3_results = {1'b0, push_int} + {1'b0, push_brd};
    end

endmodule

@@ design/g3c_out_fifo.sv @@
// result queue between the window pipeline and the output channel
// depends on g3c_pkg; takes up to two results a cycle, gives one
module g3c_out_fifo
    import g3c_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_a,
    input  result_t            data_a,
    input  logic               push_b,
    input  result_t            data_b,
    input  logic               pop,
    output logic               out_valid,
    output result_t            out_data,
    output logic [FIFO_CW-1:0] level
);

    result_t             buf_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg;
    logic [FIFO_AW-1:0]  rd_ptr_reg;
    logic [FIFO_CW-1:0]  count_reg;
    logic [FIFO_CW-1:0]  count_next;
    logic [FIFO_AW-1:0]  wr_ptr_inc;

    assign wr_ptr_inc = wr_ptr_reg + FIFO_AW'(1);

    // a is always ahead of b when both arrive together
    always_ff @(posedge aclk) begin
        if (push_a) begin
            buf_reg[wr_ptr_reg] <= data_a;
            if (push_b) begin
                buf_reg[wr_ptr_inc] <= data_b;
            end
        end else if (push_b) begin
            buf_reg[wr_ptr_reg] <= data_b;
        end
    end

    assign count_next = count_reg + FIFO_CW'(push_a) + FIFO_CW'(push_b) - FIFO_CW'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push_a) + FIFO_AW'(push_b);
            rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(pop);
            count_reg  <= count_next;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = buf_reg[rd_ptr_reg];
    assign level     = count_reg;

endmodule

@@ design/gray_3x3_convolution.sv @@
// top level of the gray 3x3 convolution block: config registers, raster
// counters, line store read stage and output credit control
// depends on g3c_pkg, g3c_line_mem, g3c_window and g3c_out_fifo
//
// Takes one RGB pixel per item in raster order, turns it into gray as
// (R+G+B)/3 and filters the 3x3 gray neighbourhood with nine 8-bit taps,
// keeping the low 8 bits of the sum as R=G=B. Each item gives zero, one or
// two result items: when pixel (c,r) arrives, the interior pixel (c-1,r-1)
// leaves first if c>=2 and r>=2, then (c,r) itself leaves unchanged if it
// lies on the image border; tlast marks the final result of an input item.
// Results therefore leave out of image order and carry their coordinates.
// An item is taken every cycle while the 8-entry output queue has room for
// two more results beyond everything in flight; the output channel sends one
// result per cycle while m_tready is high, so along the right column and the
// bottom row, where an item makes two results, the output channel and not
// the input limits the sustained item rate. A result enters the output queue
// from the tap product stage, which follows the line store read and window
// stages (the sum is formed on the way in), and can be taken the cycle after.
// The line store is one 1024 x 16 memory read at the item's column and
// written back in the next cycle; the same column comes back no sooner than
// three items later, so no forwarding is needed. Never-written line store
// entries reach a result only after a size change in mid-image.
// Configuration writes are taken at any time but belong to an idle block;
// width and height are clamped to 3..1024 and 3..4096.
module gray_3x3_convolution
    import g3c_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // pixel items in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // red 7:0, green 15:8, blue 23:16
    // result items out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // col 9:0, row 21:10, red_out 29:22,
                                             // green_out 37:30, blue_out 45:38, zero 47:46
    output logic                  m_tlast
);

    // configuration registers
    logic [WIDTH_W-1:0]  image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;
    logic [KERN_W-1:0]   kernel_top_reg;
    logic [KERN_W-1:0]   kernel_mid_reg;
    logic [KERN_W-1:0]   kernel_bot_reg;

    // raster position of the next item
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;

    // free output queue slots not yet promised to an item in flight
    logic [FIFO_CW-1:0]  credit_reg;
    logic [FIFO_CW-1:0]  credit_next;

    // line store read stage
    logic                p1_valid_reg;
    pix_meta_t           p1_meta_reg;
    logic [PIX_W-1:0]    p1_gray_reg;

    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [COL_W-1:0]    c_cur;
    logic [ROW_W-1:0]    y_cur;
    logic [WIDTH_W-1:0]  col_inc;
    logic [HEIGHT_W-1:0] row_inc;
    logic                col_wrap;
    logic                is_interior;
    logic                is_border;
    logic [1:0]          n_new;
    logic                accept;
    logic                pop;
    logic [SUM_W-1:0]    rgb_sum;
    pix_meta_t           meta_new;

    logic [LINE_W-1:0]   line_rd_data;
    logic [LINE_W-1:0]   line_wr_data;

    win_in_t             win_in;
    win_stat_t           win_stat;
    logic                push_int;
    logic                push_brd;
    result_t             res_int;
    result_t             res_brd;
    result_t             res_out;
    logic [FIFO_CW-1:0]  fifo_level;
    logic [FIFO_CW:0]    results_held;

    // configuration writes; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_W'(640);
            image_height_reg <= HEIGHT_W'(480);
            kernel_top_reg   <= KERN_W'(24'h010101);
            kernel_mid_reg   <= KERN_W'(24'h010101);
            kernel_bot_reg   <= KERN_W'(24'h010101);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[HEIGHT_W-1:0];
                CFG_KERNEL_TOP:   kernel_top_reg   <= cfg_wdata[KERN_W-1:0];
                CFG_KERNEL_MID:   kernel_mid_reg   <= cfg_wdata[KERN_W-1:0];
                CFG_KERNEL_BOT:   kernel_bot_reg   <= cfg_wdata[KERN_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped image size
    always_comb begin
        if (image_width_reg < WIDTH_W'(3)) begin
            w_eff = WIDTH_W'(3);
        end else if (image_width_reg > WIDTH_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_eff = image_width_reg;
        end
        if (image_height_reg < HEIGHT_W'(3)) begin
            h_eff = HEIGHT_W'(3);
        end else if (image_height_reg > HEIGHT_W'(MAX_HEIGHT)) begin
            h_eff = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            h_eff = image_height_reg;
        end
    end

    // position of this item; counters beyond a shrunk size restart at zero
    always_comb begin
        c_cur = (WIDTH_W'(col_reg) >= w_eff) ? '0 : col_reg;
        y_cur = (HEIGHT_W'(row_reg) >= h_eff) ? '0 : row_reg;

        is_interior = (c_cur >= COL_W'(2)) && (y_cur >= ROW_W'(2));
        is_border   = (c_cur == '0) || (WIDTH_W'(c_cur) == w_eff - WIDTH_W'(1))
                   || (y_cur == '0) || (HEIGHT_W'(y_cur) == h_eff - HEIGHT_W'(1));
        n_new       = {1'b0, is_interior} + {1'b0, is_border};

        col_inc  = WIDTH_W'(c_cur) + WIDTH_W'(1);
        col_wrap = (col_inc >= w_eff);
        row_inc  = HEIGHT_W'(y_cur) + HEIGHT_W'(1);
        col_next = col_wrap ? '0 : col_inc[COL_W-1:0];
        if (col_wrap) begin
            row_next = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            row_next = y_cur;
        end
    end

    // take an item only when the queue can hold both results it may make
    assign s_tready = (credit_reg >= FIFO_CW'(MAX_RESULTS));
    assign accept   = s_tvalid & s_tready;
    assign pop      = m_tvalid & m_tready;

    assign credit_next = credit_reg - (accept ? FIFO_CW'(n_new) : '0) + FIFO_CW'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            credit_reg   <= FIFO_CW'(FIFO_DEPTH);
            p1_valid_reg <= 1'b0;
        end else begin
            credit_reg   <= credit_next;
            p1_valid_reg <= accept;
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // gray value formed on entry, alongside the line store read
    assign rgb_sum = SUM_W'(s_tdata[7:0]) + SUM_W'(s_tdata[15:8]) + SUM_W'(s_tdata[23:16]);

    always_comb begin
        meta_new.col      = c_cur;
        meta_new.row      = y_cur;
        meta_new.red      = s_tdata[7:0];
        meta_new.green    = s_tdata[15:8];
        meta_new.blue     = s_tdata[23:16];
        meta_new.interior = is_interior;
        meta_new.border   = is_border;
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_meta_reg <= meta_new;
            p1_gray_reg <= gray_of(rgb_sum);
        end
    end

    // row above moves to the row two above, this pixel becomes the row above
    assign line_wr_data = {line_rd_data[PIX_W-1:0], p1_gray_reg};

    g3c_line_mem u_line_mem (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (c_cur),
        .rd_data (line_rd_data),
        .wr_en   (p1_valid_reg),
        .wr_addr (p1_meta_reg.col),
        .wr_data (line_wr_data)
    );

    always_comb begin
        win_in.valid = p1_valid_reg;
        win_in.meta  = p1_meta_reg;
        win_in.gray  = p1_gray_reg;
        win_in.top   = line_rd_data[LINE_W-1:PIX_W];
        win_in.mid   = line_rd_data[PIX_W-1:0];
    end

    g3c_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .win_in     (win_in),
        .kernel_top (kernel_top_reg),
        .kernel_mid (kernel_mid_reg),
        .kernel_bot (kernel_bot_reg),
        .push_int   (push_int),
        .res_int    (res_int),
        .push_brd   (push_brd),
        .res_brd    (res_brd),
        .stat       (win_stat)
    );

    // interior result goes in ahead of the border result
    g3c_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_a    (push_int),
        .data_a    (res_int),
        .push_b    (push_brd),
        .data_b    (res_brd),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_data  (res_out),
        .level     (fifo_level)
    );

    assign m_tdata = {2'b00, res_out.blue, res_out.green, res_out.red, res_out.row, res_out.col};
    assign m_tlast = res_out.last;

    // every queue slot is free, promised to an item in flight, or filled
    assign results_held = (FIFO_CW + 1)'(fifo_level)
                        + (FIFO_CW + 1)'(p1_valid_reg & p1_meta_reg.interior)
                        + (FIFO_CW + 1)'(p1_valid_reg & p1_meta_reg.border)
                        + (FIFO_CW + 1)'(win_stat.p2_results)
                        + (FIFO_CW + 1)'(win_stat.p3_results);

    assert property (@(posedge aclk) disable iff (!aresetn)
        (FIFO_CW + 1)'(credit_reg) + results_held == (FIFO_CW + 1)'(FIFO_DEPTH))
        else $error("output queue credit out of step with results held");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && n_new != 2'd0) |-> ##3 (push_int || push_brd))
        else $error("item with results did not reach the output queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg |-> (p1_meta_reg.col == $past(c_cur)) && $past(accept))
        else $error("line store write-back column differs from its read");

endmodule

@@ tb/sv/gray_conv_checker.sv @@
// result checker for gray_3x3_convolution: follows the config port and both item
// channels, predicts the results of every pixel item and compares them in order
// depends on g3c_pkg
module gray_conv_checker
    import g3c_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // red 7:0, green 15:8, blue 23:16
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // col 9:0, row 21:10, red_out 29:22,
                                             // green_out 37:30, blue_out 45:38, zero 47:46
    input  logic                  m_tlast,
    output int                    mismatch_count,
    output int                    pending_count,
    output int                    pixel_count,
    output int                    interior_count,
    output int                    border_count
);

    localparam int REPORT_LIMIT = 10;
    localparam int PAD_LSB      = COL_W + ROW_W + 3 * PIX_W;

    logic [WIDTH_W-1:0]  image_width;
    logic [HEIGHT_W-1:0] image_height;
    logic [KERN_W-1:0]   taps_top;
    logic [KERN_W-1:0]   taps_mid;
    logic [KERN_W-1:0]   taps_bot;
    logic [PIX_W-1:0]    gray_row_above [MAX_WIDTH];
    logic [PIX_W-1:0]    gray_row_above2 [MAX_WIDTH];
    // 0..2: column c-1 top/mid/bottom, 3..5: column c-2
    logic [PIX_W-1:0]    window [6];
    int unsigned         col_pos;
    int unsigned         row_pos;
    result_t             expected_results [$];

    initial begin
        foreach (gray_row_above[i]) begin
            gray_row_above[i]  = '0;
            gray_row_above2[i] = '0;
        end
    end

    function automatic int unsigned clamp(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int unsigned tap(input logic [KERN_W-1:0] taps, input int pos);
        return taps[pos*PIX_W +: PIX_W];
    endfunction

    function automatic string describe(input result_t r);
        return $sformatf("col %0d row %0d rgb %0d/%0d/%0d last %0b",
                         r.col, r.row, r.red, r.green, r.blue, r.last);
    endfunction

    // one pixel in: the interior pixel up and to the left completes, then the
    // pixel itself passes through if it sits on the border
    task automatic convolve_pixel(input logic [PIX_W-1:0] red, input logic [PIX_W-1:0] green,
                                  input logic [PIX_W-1:0] blue);
        int unsigned w, h, c, y, gray, top, mid, acc;
        int          n;
        result_t     produced [2];
        w = clamp(image_width, 3, MAX_WIDTH);
        h = clamp(image_height, 3, MAX_HEIGHT);
        n = 0;
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        c    = col_pos;
        y    = row_pos;
        gray = (int'(red) + int'(green) + int'(blue)) / 3;
        top  = gray_row_above2[c];
        mid  = gray_row_above[c];
        if (c >= 2 && y >= 2) begin
            acc = tap(taps_top, 0) * window[3] + tap(taps_top, 1) * window[0]
                + tap(taps_top, 2) * top
                + tap(taps_mid, 0) * window[4] + tap(taps_mid, 1) * window[1]
                + tap(taps_mid, 2) * mid
                + tap(taps_bot, 0) * window[5] + tap(taps_bot, 1) * window[2]
                + tap(taps_bot, 2) * gray;
            produced[n].col   = COL_W'(c - 1);
            produced[n].row   = ROW_W'(y - 1);
            produced[n].red   = PIX_W'(acc);
            produced[n].green = PIX_W'(acc);
            produced[n].blue  = PIX_W'(acc);
            produced[n].last  = 1'b0;
            n++;
            interior_count++;
        end
        if (c == 0 || c == w - 1 || y == 0 || y == h - 1) begin
            produced[n].col   = COL_W'(c);
            produced[n].row   = ROW_W'(y);
            produced[n].red   = red;
            produced[n].green = green;
            produced[n].blue  = blue;
            produced[n].last  = 1'b0;
            n++;
            border_count++;
        end
        if (n > 0) produced[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) expected_results.push_back(produced[i]);

        window[3] = window[0];
        window[4] = window[1];
        window[5] = window[2];
        window[0] = PIX_W'(top);
        window[1] = PIX_W'(mid);
        window[2] = PIX_W'(gray);
        gray_row_above2[c] = PIX_W'(mid);
        gray_row_above[c]  = PIX_W'(gray);

        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = y + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            image_width    = 11'd640;
            image_height   = 13'd480;
            taps_top       = 24'h010101;
            taps_mid       = 24'h010101;
            taps_bot       = 24'h010101;
            window         = '{default: '0};
            col_pos        = 0;
            row_pos        = 0;
            mismatch_count = 0;
            pixel_count    = 0;
            interior_count = 0;
            border_count   = 0;
            expected_results.delete();
            pending_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  image_width  = cfg_wdata[WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT: image_height = cfg_wdata[HEIGHT_W-1:0];
                    CFG_KERNEL_TOP:   taps_top     = cfg_wdata[KERN_W-1:0];
                    CFG_KERNEL_MID:   taps_mid     = cfg_wdata[KERN_W-1:0];
                    CFG_KERNEL_BOT:   taps_bot     = cfg_wdata[KERN_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.col   = m_tdata[COL_W-1:0];
                got.row   = m_tdata[COL_W +: ROW_W];
                got.red   = m_tdata[COL_W + ROW_W +: PIX_W];
                got.green = m_tdata[COL_W + ROW_W + PIX_W +: PIX_W];
                got.blue  = m_tdata[COL_W + ROW_W + 2*PIX_W +: PIX_W];
                got.last  = m_tlast;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: result with nothing expected: %s", $time, describe(got));
                end else begin
                    want = expected_results.pop_front();
                    if (got.col !== want.col || got.row !== want.row || got.red !== want.red
                            || got.green !== want.green || got.blue !== want.blue
                            || got.last !== want.last || m_tdata[OUT_DATA_W-1:PAD_LSB] !== '0) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: mismatch, expected %s, got %s pad %b", $time,
                                     describe(want), describe(got),
                                     m_tdata[OUT_DATA_W-1:PAD_LSB]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pixel_count++;
                convolve_pixel(s_tdata[PIX_W-1:0], s_tdata[PIX_W +: PIX_W],
                               s_tdata[2*PIX_W +: PIX_W]);
            end
            pending_count <= expected_results.size();
        end
    end

endmodule

@@ tb/sv/gray_3x3_convolution_test.sv @@
// testbench top for gray_3x3_convolution: clock, reset, config writes, pixel
// stimulus with random idling on both sides, and the verdict
// depends on g3c_pkg, gray_3x3_convolution and gray_conv_checker
module gray_3x3_convolution_test
    import g3c_pkg::*;
();

    // cycles to let a result-less item clear the pipeline before a config write
    localparam int DRAIN_CYCLES  = 12;
    // random frames on top of the directed pixels, about 1800 items in all
    localparam int RANDOM_PIXELS = 700;
    // an index that maps to no register; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // red 7:0, green 15:8, blue 23:16
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // col 9:0, row 21:10, red_out 29:22,
                                             // green_out 37:30, blue_out 45:38, zero 47:46
    logic                  m_tlast;

    // when set, neither the pixel source nor the result sink idles
    logic calm = 1'b0;

    int mismatch_count;
    int pending_count;
    int pixel_count;
    int interior_count;
    int border_count;
    int random_pixels  = 0;
    int settings_count = 0;

    gray_3x3_convolution dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    gray_conv_checker result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .pixel_count    (pixel_count),
        .interior_count (interior_count),
        .border_count   (border_count)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // one register write per call; the enable drops on the following edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h,
                             input logic [KERN_W-1:0] top, input logic [KERN_W-1:0] mid,
                             input logic [KERN_W-1:0] bot);
        write_reg(CFG_IMAGE_WIDTH,  CFG_DATA_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_KERNEL_TOP,   top);
        write_reg(CFG_KERNEL_MID,   mid);
        write_reg(CFG_KERNEL_BOT,   bot);
        settings_count++;
    endtask

    // offer one pixel item after a random idle stretch and wait for it to be taken;
    // valid stays high between back-to-back items
    task automatic send_pixel(input logic [PIX_W-1:0] red, input logic [PIX_W-1:0] green,
                              input logic [PIX_W-1:0] blue);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {blue, green, red};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // mostly uniform levels, with black and full scale weighted up
    function automatic logic [PIX_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [KERN_W-1:0] pick_taps();
        case ($urandom_range(0, 5))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return 24'h010101;
            default: return KERN_W'($urandom);
        endcase
    endfunction

    task automatic send_random_pixels(input int count);
        repeat (count) send_pixel(pick_level(), pick_level(), pick_level());
    endtask

    // extremes of the color fields, laid out as one 3x3 image
    task automatic send_corner_image();
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hFF);
        send_pixel(8'hFF, 8'hFF, 8'hFE);
        send_pixel(8'h01, 8'h01, 8'h01);
        send_pixel(8'h80, 8'h7F, 8'h40);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
    endtask

    // stop sending and wait until every expected result has been taken, then
    // give a result-less last item time to leave the pipeline
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // result sink: random stall before each result, none while calm
    initial begin
        int gap;
        @(posedge aclk);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin
        int w;
        int h;
        int images;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings (640 x 480, all taps one): a few pixels along the top border
        send_random_pixels(4);
        drain();
        // width and height below the minimum clamp to 3; the column counter sits
        // beyond the new width and wraps to zero, the window keeps what it had
        write_reg(CFG_IMAGE_WIDTH,  24'd0);
        write_reg(CFG_IMAGE_HEIGHT, 24'd1);
        settings_count++;
        send_corner_image();
        drain();

        // full-scale taps, sizes again clamped up; a write to an unused index is ignored
        write_reg(CFG_UNUSED_INDEX, 24'hFFFFFF);
        set_frame(2, 2, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_corner_image();
        drain();
        // all taps zero: every interior pixel becomes black
        set_frame(3, 3, 24'h000000, 24'h000000, 24'h000000);
        send_corner_image();
        drain();

        // widest image: width above the maximum clamps to 1024; run through row 0
        // and into row 1, then shrink the width mid-image so the column wraps back
        // to the start of row 1; the upper bits of the written value are ignored
        set_frame(2047, 3, pick_taps(), pick_taps(), pick_taps());
        send_random_pixels(MAX_WIDTH + 8);
        drain();
        write_reg(CFG_IMAGE_WIDTH, 24'hABC806);
        settings_count++;
        send_random_pixels(12);
        drain();

        // tallest image: height above the maximum clamps to 4096; after five rows
        // and a bit the height shrinks to 4, so the row counter wraps to row 0
        set_frame(3, 8191, pick_taps(), pick_taps(), pick_taps());
        send_random_pixels(16);
        drain();
        write_reg(CFG_IMAGE_HEIGHT, 24'hFFE004);
        settings_count++;
        send_random_pixels(11);
        drain();

        // random frames: mostly narrow, some wider; whole images each, so every
        // size change happens with the counters back at the top left corner
        while (random_pixels < RANDOM_PIXELS) begin
            w      = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 48) : $urandom_range(3, 12);
            h      = ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(3, 8);
            images = $urandom_range(1, 2);
            calm   = ($urandom_range(0, 3) == 0);
            set_frame(w, h, pick_taps(), pick_taps(), pick_taps());
            send_random_pixels(images * w * h);
            random_pixels += images * w * h;
            drain();
        end

        calm = 1'b0;
        drain();
        $display("covered %0d pixel items over %0d frame settings:",
                 pixel_count, settings_count);
        $display("  %0d filtered and %0d border results", interior_count, border_count);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("** gray_3x3_convolution: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results never seen", mismatch_count, pending_count);
            $display("** gray_3x3_convolution: FAILED **");
        end
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #(64'd20 * 64'd1000000);
        $display("timeout with %0d results still expected", pending_count);
        $display("** gray_3x3_convolution: FAILED **");
        $finish;
    end

endmodule

@@ gray_3x3_convolution.f @@
design/g3c_pkg.sv
design/g3c_line_mem.sv
design/g3c_window.sv
design/g3c_out_fifo.sv
design/gray_3x3_convolution.sv
tb/sv/gray_conv_checker.sv
tb/sv/gray_3x3_convolution_test.sv
